// File: rtl/spjq_pkg.sv
`timescale 1ns / 1ps

package spjq_pkg;

  // default number of job slots
  localparam int unsigned QueueDepth = 16;

  // field widths
  localparam int unsigned UserW   = 8;
  localparam int unsigned PriW    = 4;
  localparam int unsigned EntryW  = UserW + PriW;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 5;

  // result status codes
  localparam logic [StatusW-1:0] StAdded  = 2'd0;
  localparam logic [StatusW-1:0] StServed = 2'd1;
  localparam logic [StatusW-1:0] StEmpty  = 2'd2;
  localparam logic [StatusW-1:0] StFull   = 2'd3;

  // input command codes
  localparam logic CmdAdd   = 1'b0;
  localparam logic CmdServe = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic scan_rd;
    logic shift_init;
    logic shift_rd;
    logic finish;
    logic load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic serve_go;
    logic scan_last;
    logic shift_more;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/spjq_ctrl.sv
`timescale 1ns / 1ps

module spjq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spjq_pkg::sts_t    sts_i,
  output spjq_pkg::cmd_t    cmd_o
);
  import spjq_pkg::*;

  typedef enum logic [2:0] {
    Idle,
    Scan,
    ScanTail,
    ShiftInit,
    Shift,
    Result
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      Idle: begin
        if (in_valid_i && rdy_q) begin
          cmd_o.take = 1'b1;
          state_d    = sts_i.serve_go ? Scan : Result;
        end
      end
      Scan: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ScanTail;
        end
      end
      ScanTail: begin
        state_d = ShiftInit;
      end
      ShiftInit: begin
        cmd_o.shift_init = 1'b1;
        state_d          = Shift;
      end
      Shift: begin
        if (sts_i.shift_more) begin
          cmd_o.shift_rd = 1'b1;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = Result;
        end
      end
      Result: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = Idle;
        end
      end
      default: begin
        state_d = Idle;
      end
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      rdy_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rdy_q   <= (state_d == Idle);
    end
  end

  assign in_ready_o = rdy_q;

endmodule

// File: rtl/spjq_dp.sv
`timescale 1ns / 1ps

module spjq_dp #(
  parameter int unsigned QUEUE_DEPTH = spjq_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spjq_pkg::cmd_t                cmd_i,
  output spjq_pkg::sts_t                sts_o,
  input  logic                          in_cmd_i,
  input  logic [spjq_pkg::UserW-1:0]    in_user_i,
  input  logic [spjq_pkg::PriW-1:0]     in_pri_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [spjq_pkg::StatusW-1:0]  out_status_o,
  output logic [spjq_pkg::UserW-1:0]    out_user_o,
  output logic [spjq_pkg::PriW-1:0]     out_pri_o,
  output logic [spjq_pkg::OccW-1:0]     out_occ_o
);
  import spjq_pkg::*;

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(QUEUE_DEPTH);

  // job store, arrival order from slot zero up
  logic [EntryW-1:0] mem [QUEUE_DEPTH];
  logic [EntryW-1:0] rdata_q;

  logic [CW-1:0]     count_q;
  logic [CW-1:0]     ptr_q;
  logic              rdv_q;
  logic [IW-1:0]     rd_idx_q;
  logic              shift_mode_q;
  logic [IW-1:0]     best_idx_q;
  logic [EntryW-1:0] best_ent_q;

  logic [StatusW-1:0] pend_st_q;
  logic [UserW-1:0]   pend_user_q;
  logic [PriW-1:0]    pend_pri_q;

  logic              out_valid_q;
  logic [StatusW-1:0] out_st_q;
  logic [UserW-1:0]  out_user_q;
  logic [PriW-1:0]   out_pri_q;
  logic [OccW-1:0]   out_occ_q;

  logic              is_full;
  logic              is_empty;
  logic              add_we;
  logic              shift_we;
  logic              mem_we;
  logic [IW-1:0]     waddr;
  logic [EntryW-1:0] wdata;
  logic              mem_re;
  logic              better;

  assign is_full  = (count_q == Full);
  assign is_empty = (count_q == '0);

  // write port: append on add, move down by one during compaction
  assign add_we   = cmd_i.take && (in_cmd_i == CmdAdd) && !is_full;
  assign shift_we = rdv_q && shift_mode_q;
  assign mem_we   = add_we || shift_we;
  assign waddr    = add_we ? count_q[IW-1:0] : (rd_idx_q - 1'b1);
  assign wdata    = add_we ? {in_user_i, in_pri_i} : rdata_q;
  assign mem_re   = cmd_i.scan_rd || cmd_i.shift_rd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[ptr_q[IW-1:0]];
    end
  end

  // strict less-than keeps the earliest job among equal priorities
  assign better = (rd_idx_q == '0) || (rdata_q[PriW-1:0] < best_ent_q[PriW-1:0]);

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_idx_q <= ptr_q[IW-1:0];
    end
    if (rdv_q && !shift_mode_q && better) begin
      best_idx_q <= rd_idx_q;
      best_ent_q <= rdata_q;
    end
  end

  // count, scan pointer and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      ptr_q        <= '0;
      rdv_q        <= 1'b0;
      shift_mode_q <= 1'b0;
    end else begin
      rdv_q <= mem_re;
      if (add_we) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.finish) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.take) begin
        ptr_q <= '0;
      end else if (cmd_i.shift_init) begin
        ptr_q <= CW'(best_idx_q) + 1'b1;
      end else if (mem_re) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.shift_init) begin
        shift_mode_q <= 1'b1;
      end else if (cmd_i.finish) begin
        shift_mode_q <= 1'b0;
      end
    end
  end

  // pending result
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pend_user_q <= '0;
      pend_pri_q  <= '0;
      if (in_cmd_i == CmdAdd) begin
        pend_st_q <= is_full ? StFull : StAdded;
      end else begin
        pend_st_q <= StEmpty;
      end
    end else if (cmd_i.finish) begin
      pend_st_q   <= StServed;
      pend_user_q <= best_ent_q[EntryW-1:PriW];
      pend_pri_q  <= best_ent_q[PriW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_st_q   <= pend_st_q;
      out_user_q <= pend_user_q;
      out_pri_q  <= pend_pri_q;
      out_occ_q  <= OccW'(count_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_st_q;
  assign out_user_o   = out_user_q;
  assign out_pri_o    = out_pri_q;
  assign out_occ_o    = out_occ_q;

  // status to controller
  assign sts_o.serve_go   = (in_cmd_i == CmdServe) && !is_empty;
  assign sts_o.scan_last  = (ptr_q == count_q - 1'b1);
  assign sts_o.shift_more = (ptr_q < count_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("job count above depth");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(add_we && shift_we))
    else $error("append and compaction write in the same cycle");

  a_finish_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (count_q == $past(count_q) - 1'b1))
    else $error("serve did not remove exactly one job");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdv_q && !shift_mode_q) |-> (CW'(rd_idx_q) < count_q))
    else $error("scan read beyond waiting jobs");

endmodule

// File: rtl/stable_priority_job_queue_unit.sv
`timescale 1ns / 1ps
// add, dropped add or empty serve: Idle takes the input beat, Result loads the output register
// serve with waiting jobs: one serial scan of the job store, then one compaction pass
// over the slots after the winner, one slot a cycle
// one job in flight; next input beat taken in the cycle after the result is registered
// reset: asynchronous active low; count and handshake cleared, store contents left as is

module stable_priority_job_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = spjq_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // user_id[7:0], priority_req[11:8], zero pad
  input  logic        s_axis_tuser_i,   // command[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // served_user[7:0], served_priority[11:8],
                                        // occupancy[16:12], zero pad
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);
  import spjq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [UserW-1:0] out_user;
  logic [PriW-1:0]  out_pri;
  logic [OccW-1:0]  out_occ;

  spjq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spjq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_cmd_i     (s_axis_tuser_i),
    .in_user_i    (s_axis_tdata_i[7:0]),
    .in_pri_i     (s_axis_tdata_i[11:8]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_status_o (m_axis_tuser_o),
    .out_user_o   (out_user),
    .out_pri_o    (out_pri),
    .out_occ_o    (out_occ)
  );

  // pack result beat
  assign m_axis_tdata_o = {7'd0, out_occ, out_pri, out_user};

endmodule
